### rtl/core/assert_macros.svh
// assertion macros for the rtl files (included by the decoder top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion violated");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/csed_pkg.sv
// types, codes and helpers for the string escape decoder
`timescale 1ns / 1ps
`default_nettype none

package csed_pkg;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX1  = 2'd2;
  localparam logic [1:0] MODE_HEX2  = 2'd3;

  localparam logic [1:0] ST_BYTE    = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_BADESC  = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_APOS   = 8'd39;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_A      = 8'd97;
  localparam logic [7:0] CH_B      = 8'd98;
  localparam logic [7:0] CH_F      = 8'd102;
  localparam logic [7:0] CH_N      = 8'd110;
  localparam logic [7:0] CH_R      = 8'd114;
  localparam logic [7:0] CH_T      = 8'd116;
  localparam logic [7:0] CH_V      = 8'd118;
  localparam logic [7:0] CH_X      = 8'd120;

  localparam logic [7:0] CTL_BEL = 8'd7;
  localparam logic [7:0] CTL_BS  = 8'd8;
  localparam logic [7:0] CTL_HT  = 8'd9;
  localparam logic [7:0] CTL_LF  = 8'd10;
  localparam logic [7:0] CTL_VT  = 8'd11;
  localparam logic [7:0] CTL_FF  = 8'd12;
  localparam logic [7:0] CTL_CR  = 8'd13;

  typedef struct packed {
    logic       emit;
    logic [7:0] res_byte;
    logic [1:0] res_status;
    logic [1:0] mode_next;
    logic [3:0] nibble_next;
  } step_t;

  // bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
        d = c - 8'd48;
      end else if (c >= 8'd97 && c <= 8'd102) begin
        d = c - 8'd87;
      end else if (c >= 8'd65 && c <= 8'd70) begin
        d = c - 8'd55;
      end else begin
        d = 8'd16;
      end
      hex_value = d[4:0];
    end
  endfunction

  function automatic logic plain_ok(input logic [7:0] c);
    plain_ok = (c >= 8'd32 && c <= 8'd33) || (c >= 8'd35 && c <= 8'd38) ||
               (c >= 8'd40 && c <= 8'd91) || (c >= 8'd93 && c <= 8'd126);
  endfunction

endpackage

`default_nettype wire

### rtl/core/c_string_escape_decoder.sv
// top level of the c string literal escape decoder
//
//  channel | signals                      | direction
//  --------+------------------------------+----------
//  in      | in_valid in_ready in_byte    | sink
//  out     | out_valid out_ready out_byte | source
//          | status                       |
//
// one byte per cycle while the output is not stalled; each byte passes the input register, then the result register
// the escape mode and hex nibble update as a byte leaves the input register
// bytes that start an escape, the x of a hex escape or the first hex digit give no transaction
// a stalled output holds the input register; reset returns to plain mode
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module c_string_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] status
);
  import csed_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [1:0] mode;
  logic [3:0] high_nibble;
  logic       free;
  logic       advance;
  step_t      step;

  assign advance  = s1_valid && free;
  assign in_ready = !s1_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      high_nibble <= 4'd0;
    end else if (advance) begin
      mode        <= step.mode_next;
      high_nibble <= step.nibble_next;
    end
  end

  csed_decode u_decode (
    .cur_byte    (s1_byte),
    .mode        (mode),
    .high_nibble (high_nibble),
    .step        (step)
  );

  csed_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && step.emit),
    .ld_byte   (step.res_byte),
    .ld_status (step.res_status),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .status    (status)
  );

  `ASSERT_NEXT(a_emit_to_plain, clk, rst, advance && step.emit, mode == MODE_PLAIN)
  `ASSERT_ALWAYS(a_end_zero, clk, rst, !(out_valid && status == ST_END) || out_byte == 8'd0)
  `ASSERT_ALWAYS(a_ready_when_empty, clk, rst, out_valid || in_ready)
  `ASSERT_NEXT(a_hex2_entry, clk, rst, advance && mode == MODE_HEX1 && !step.emit, mode == MODE_HEX2)

endmodule

`default_nettype wire

### rtl/core/csed_decode.sv
// next-state and result logic for one input byte
`timescale 1ns / 1ps
`default_nettype none

module csed_decode (
  input  logic [7:0]     cur_byte,
  input  logic [1:0]     mode,
  input  logic [3:0]     high_nibble,
  output csed_pkg::step_t step
);
  import csed_pkg::*;

  logic [4:0] hv;

  assign hv = hex_value(cur_byte);

  always_comb begin
    step.emit        = 1'b1;
    step.res_byte    = cur_byte;
    step.res_status  = ST_BYTE;
    step.mode_next   = MODE_PLAIN;
    step.nibble_next = high_nibble;
    unique case (mode)
      MODE_PLAIN: begin
        if (cur_byte == CH_BSLASH) begin
          step.emit      = 1'b0;
          step.mode_next = MODE_ESC;
        end else if (cur_byte == CH_QUOTE) begin
          step.res_byte   = 8'd0;
          step.res_status = ST_END;
        end else if (!plain_ok(cur_byte)) begin
          step.res_status = ST_ILLEGAL;
        end
      end
      MODE_ESC: begin
        unique case (cur_byte)
          CH_BSLASH, CH_QUOTE, CH_APOS: step.res_byte = cur_byte;
          CH_N: step.res_byte = CTL_LF;
          CH_R: step.res_byte = CTL_CR;
          CH_T: step.res_byte = CTL_HT;
          CH_F: step.res_byte = CTL_FF;
          CH_V: step.res_byte = CTL_VT;
          CH_B: step.res_byte = CTL_BS;
          CH_A: step.res_byte = CTL_BEL;
          CH_X: begin
            step.emit      = 1'b0;
            step.mode_next = MODE_HEX1;
          end
          default: step.res_status = ST_BADESC;
        endcase
      end
      MODE_HEX1: begin
        if (hv[4]) begin
          step.res_status = ST_BADESC;
        end else begin
          step.emit        = 1'b0;
          step.mode_next   = MODE_HEX2;
          step.nibble_next = hv[3:0];
        end
      end
      MODE_HEX2: begin
        if (hv[4]) begin
          step.res_status = ST_BADESC;
        end else begin
          step.res_byte = {high_nibble, hv[3:0]};
        end
      end
      default: step.emit = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/csed_outreg.sv
// result register with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none

module csed_outreg (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] ld_byte,
  input  logic [1:0] ld_status,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] status
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_byte <= ld_byte;
      status   <= ld_status;
    end
  end

endmodule

`default_nettype wire

### test/csed_decode_check.sv
// checker for the string escape decoder: predicts each decoded transaction and compares it
`timescale 1ns / 1ps

module csed_decode_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [1:0] status,
  output int         errors,
  output int         pending
);
  import csed_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] code;
  } decoded_t;

  decoded_t   decoded_q[$];
  logic [1:0] esc_mode;
  logic [3:0] first_digit;

  initial begin
    errors = 0;
    pending = 0;
    esc_mode = MODE_PLAIN;
    first_digit = 4'd0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 50) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
    hex_digit = 1'b1;
    v = c[3:0];
    if (c >= 8'd48 && c <= 8'd57) begin
      v = c[3:0];
    end else if ((c >= 8'd97 && c <= 8'd102) || (c >= 8'd65 && c <= 8'd70)) begin
      v = c[3:0] + 4'd9;
    end else begin
      hex_digit = 1'b0;
    end
  endfunction

  // advances the escape state by one byte; returns 1 when a transaction follows
  function automatic logic unescape(input logic [7:0] c, output decoded_t d);
    logic [3:0] v;
    logic       ok;
    d = '{data: c, code: ST_BYTE};
    unescape = 1'b1;
    ok = hex_digit(c, v);
    case (esc_mode)
      MODE_PLAIN: begin
        if (c == CH_BSLASH) begin
          esc_mode = MODE_ESC;
          unescape = 1'b0;
        end else if (c == CH_QUOTE) begin
          d = '{data: 8'd0, code: ST_END};
        end else if (c < 8'd32 || c > 8'd126 || c == CH_APOS) begin
          d.code = ST_ILLEGAL;
        end
      end
      MODE_ESC: begin
        case (c)
          CH_BSLASH, CH_QUOTE, CH_APOS: d.data = c;
          CH_N: d.data = CTL_LF;
          CH_R: d.data = CTL_CR;
          CH_T: d.data = CTL_HT;
          CH_F: d.data = CTL_FF;
          CH_V: d.data = CTL_VT;
          CH_B: d.data = CTL_BS;
          CH_A: d.data = CTL_BEL;
          CH_X: begin
            esc_mode = MODE_HEX1;
            unescape = 1'b0;
          end
          default: d.code = ST_BADESC;
        endcase
      end
      MODE_HEX1: begin
        if (ok) begin
          first_digit = v;
          esc_mode = MODE_HEX2;
          unescape = 1'b0;
        end else begin
          d.code = ST_BADESC;
        end
      end
      default: begin
        if (ok) begin
          d.data = {first_digit, v};
        end else begin
          d.code = ST_BADESC;
        end
      end
    endcase
    if (unescape) begin
      esc_mode = MODE_PLAIN;
    end
  endfunction

  always @(posedge clk) begin : monitor
    decoded_t want;
    decoded_t next;
    if (rst) begin
      esc_mode = MODE_PLAIN;
      first_digit = 4'd0;
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, byte %0d status %0d",
                                    out_byte, status));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            report_mismatch($sformatf("out_byte %0d, expected %0d", out_byte, want.data));
          end
          if (status !== want.code) begin
            report_mismatch($sformatf("status %0d, expected %0d", status, want.code));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (unescape(in_byte, next)) begin
          decoded_q.push_back(next);
        end
      end
    end
    pending <= decoded_q.size();
  end

endmodule

### test/tb_c_string_escape_decoder.sv
// testbench top for the string escape decoder: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module tb_c_string_escape_decoder;
  import csed_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BYTES = 1950;
  localparam int HOLD_CYCLES  = 400;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] status;
  int         errors;
  int         pending;
  int         sent = 0;
  bit         steady = 1'b0;
  bit         long_hold = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  c_string_escape_decoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .status(status)
  );

  csed_decode_check decode_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .status(status),
    .errors(errors),
    .pending(pending)
  );

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) begin
      return 8'd48 + v;
    end
    return upper ? 8'd55 + v : 8'd87 + v;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd70) ||
               (b >= 8'd97 && b <= 8'd102));
    return b;
  endfunction

  function automatic logic [7:0] random_hex_char();
    return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic offer_byte(input logic [7:0] b);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic offer_escape(input logic [7:0] c);
    offer_byte(CH_BSLASH);
    offer_byte(c);
  endtask

  // waits until every expected transaction has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic offer_token();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      offer_byte(8'($urandom_range(32, 126)));
    end else if (kind < 55) begin
      case ($urandom_range(0, 9))
        0: offer_escape(CH_BSLASH);
        1: offer_escape(CH_QUOTE);
        2: offer_escape(CH_APOS);
        3: offer_escape(CH_N);
        4: offer_escape(CH_R);
        5: offer_escape(CH_T);
        6: offer_escape(CH_F);
        7: offer_escape(CH_V);
        8: offer_escape(CH_B);
        default: offer_escape(CH_A);
      endcase
    end else if (kind < 72) begin
      offer_escape(CH_X);
      offer_byte(random_hex_char());
      offer_byte(random_hex_char());
    end else if (kind < 77) begin
      offer_byte(CH_QUOTE);
    end else if (kind < 89) begin
      offer_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        0: offer_escape(8'($urandom_range(0, 255)));
        1: begin
          offer_escape(CH_X);
          offer_byte(non_hex_byte());
        end
        default: begin
          offer_escape(CH_X);
          offer_byte(random_hex_char());
          offer_byte(non_hex_byte());
        end
      endcase
    end
  endtask

  initial begin : sink
    int n;
    wait (!rst);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_byte(8'd0);
    offer_byte(8'd255);
    offer_byte(8'd32);
    offer_byte(8'd126);
    offer_byte(CH_APOS);
    offer_byte(CH_QUOTE);
    offer_escape(CH_BSLASH);
    offer_escape(CH_QUOTE);
    offer_escape(CH_APOS);
    offer_escape(CH_N);
    offer_escape(CH_R);
    offer_escape(CH_T);
    offer_escape(CH_F);
    offer_escape(CH_V);
    offer_escape(CH_B);
    offer_escape(CH_A);
    offer_escape(CH_X);
    offer_byte("a");
    offer_byte("F");
    offer_escape(CH_X);
    offer_byte("g");
    offer_escape(CH_X);
    offer_byte("5");
    offer_byte("z");
    offer_escape("q");
    drain();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (!steady && $urandom_range(0, 199) == 0) begin
        steady = 1'b1;
      end else if (steady && $urandom_range(0, 29) == 0) begin
        steady = 1'b0;
      end
      // output held off for a long stretch while bytes keep coming
      if (!held && sent >= 600) begin
        held = 1'b1;
        long_hold = 1'b1;
      end
      if (!paused && sent >= 1300) begin
        paused = 1'b1;
        drain();
      end
      offer_token();
    end
    drain();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
